### design/iig_pkg.sv
// iig_pkg: shared constants and types of the integral image generator
`timescale 1ns / 1ps

package iig_pkg;

  // frame geometry and arithmetic widths
  localparam int MAX_WIDTH   = 1024;
  localparam int SUM_BITS    = 48;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = 11;
  localparam int SAMPLE_BITS = 16;
  localparam int AREA_BITS   = 48;
  // one row of samples never overflows this
  localparam int ROW_BITS    = SAMPLE_BITS + COL_BITS + 1;

  // item held between the accept stage and the add stage
  typedef struct packed {
    logic [COL_BITS-1:0]        col;
    logic signed [ROW_BITS-1:0] row_sum;
    logic                       first_row;
    logic                       row_end;
  } s1_t;

  // line store write, also used for forwarding
  typedef struct packed {
    logic                en;
    logic [COL_BITS-1:0] addr;
    logic [SUM_BITS-1:0] data;
  } wr_t;

endpackage

### design/iig_if.sv
// iig_if: valid/ready channel interfaces for samples and results
`timescale 1ns / 1ps

interface iig_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iig_pkg::SAMPLE_BITS-1:0] sample;
  logic                                 frame_start;

  modport source (output valid, sample, frame_start, input ready);
  modport sink   (input valid, sample, frame_start, output ready);
endinterface

interface iig_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [iig_pkg::AREA_BITS-1:0] area_sum;
  logic                                 row_end;

  modport source (output valid, area_sum, row_end, input ready);
  modport sink   (input valid, area_sum, row_end, output ready);
endinterface

### design/iig_ram.sv
// iig_ram: generic single-write, single-read RAM with registered read
`timescale 1ns / 1ps

module iig_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### design/iig_front.sv
// iig_front: accept stage, width register, column and row-sum tracking, line store read
`timescale 1ns / 1ps

module iig_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [iig_pkg::WIDTH_BITS-1:0]     cfg_wdata,
  iig_in_if.sink                             in_ch,
  input  logic                               s1_adv,
  input  iig_pkg::wr_t                       wr,
  output logic                               rd_en,
  output logic [iig_pkg::COL_BITS-1:0]       rd_addr,
  output iig_pkg::s1_t                       s1,
  output logic                               s1_valid,
  output logic                               fwd,
  output logic [iig_pkg::SUM_BITS-1:0]       fwd_data
);

  logic [iig_pkg::WIDTH_BITS-1:0]     width_r;
  logic [iig_pkg::COL_BITS-1:0]       col_r, col_nxt;
  logic signed [iig_pkg::ROW_BITS-1:0] row_r, row_nxt;
  logic                               first_r, first_nxt;
  logic                               s1_valid_r, s1_valid_nxt;
  iig_pkg::s1_t                       s1_r;
  logic                               fwd_r;
  logic [iig_pkg::SUM_BITS-1:0]       fwd_data_r;

  logic [iig_pkg::WIDTH_BITS-1:0]     w_eff;
  logic [iig_pkg::COL_BITS-1:0]       col_cur;
  logic signed [iig_pkg::ROW_BITS-1:0] row_cur, row_new;
  logic                               first_cur;
  logic                               last;
  logic                               acc;
  logic                               ready;

  // width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= iig_pkg::WIDTH_BITS'(iig_pkg::MAX_WIDTH);
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
    end
  end

  // width clamped to 1..MAX_WIDTH
  always_comb begin
    if (width_r == '0) begin
      w_eff = iig_pkg::WIDTH_BITS'(1);
    end else if (width_r > iig_pkg::WIDTH_BITS'(iig_pkg::MAX_WIDTH)) begin
      w_eff = iig_pkg::WIDTH_BITS'(iig_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
  end

  // handshake, nothing taken while in reset
  assign ready       = rst_n && (!s1_valid_r || s1_adv);
  assign in_ch.ready = ready;
  assign acc         = in_ch.valid && ready;

  // position of this beat, frame start restarts everything
  always_comb begin
    col_cur   = in_ch.frame_start ? '0 : col_r;
    row_cur   = in_ch.frame_start ? '0 : row_r;
    first_cur = in_ch.frame_start || first_r;
    row_new   = row_cur + iig_pkg::ROW_BITS'(in_ch.sample);
    last      = ({1'b0, col_cur} + iig_pkg::WIDTH_BITS'(1)) >= w_eff;
  end

  // row tracking next state
  always_comb begin
    col_nxt   = col_r;
    row_nxt   = row_r;
    first_nxt = first_r;
    if (acc) begin
      if (last) begin
        col_nxt   = '0;
        row_nxt   = '0;
        first_nxt = 1'b0;
      end else begin
        col_nxt   = col_cur + iig_pkg::COL_BITS'(1);
        row_nxt   = row_new;
        first_nxt = first_cur;
      end
    end
  end

  always_comb begin
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      first_r    <= 1'b1;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      first_r    <= first_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // stage payload, forward a write to the same column landing this cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r.col       <= col_cur;
      s1_r.row_sum   <= row_new;
      s1_r.first_row <= first_cur;
      s1_r.row_end   <= last;
      fwd_r          <= wr.en && (wr.addr == col_cur);
      fwd_data_r     <= wr.data;
    end
  end

  assign rd_en    = acc;
  assign rd_addr  = col_cur;
  assign s1       = s1_r;
  assign s1_valid = s1_valid_r;
  assign fwd      = fwd_r;
  assign fwd_data = fwd_data_r;

endmodule

### design/iig_back.sv
// iig_back: adds the row above, writes the line store and holds the result beat
`timescale 1ns / 1ps

module iig_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  iig_pkg::s1_t                 s1,
  input  logic                         s1_valid,
  input  logic                         fwd,
  input  logic [iig_pkg::SUM_BITS-1:0] fwd_data,
  input  logic [iig_pkg::SUM_BITS-1:0] rd_data,
  output logic                         s1_adv,
  output iig_pkg::wr_t                 wr,
  iig_out_if.source                    out_ch
);

  logic [iig_pkg::SUM_BITS-1:0]         above;
  logic [iig_pkg::SUM_BITS-1:0]         total;
  logic                                 out_valid_r, out_valid_nxt;
  logic signed [iig_pkg::AREA_BITS-1:0] area_r;
  logic                                 row_end_r;

  // stage moves when the output register is free or draining
  assign s1_adv = s1_valid && (!out_valid_r || out_ch.ready);

  // value above, zero on the first row
  always_comb begin
    if (s1.first_row) begin
      above = '0;
    end else if (fwd) begin
      above = fwd_data;
    end else begin
      above = rd_data;
    end
    total = above + iig_pkg::SUM_BITS'(s1.row_sum);
  end

  // line store write back
  always_comb begin
    wr.en   = s1_adv;
    wr.addr = s1.col;
    wr.data = total;
  end

  always_comb begin
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      area_r    <= iig_pkg::AREA_BITS'($signed(total));
      row_end_r <= s1.row_end;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.area_sum = area_r;
  assign out_ch.row_end  = row_end_r;

endmodule

### design/integral_image_generator.sv
// integral_image_generator: top level of the summed-area table generator
`timescale 1ns / 1ps

// Takes one signed sample per beat in raster order and returns one summed-area
// value per beat, with row_end on the last column of each row. A beat marked
// frame_start restarts at row zero, column zero; after reset the block is
// already at a frame start. Throughput is one beat per clock while out_ch.ready
// is high. A result passes the accept stage and the registered line store read
// (at most one read, one write per clock), then the output register. The user
// must write the row width through cfg_we/cfg_wdata only while the block is
// idle (not enforced); 0 acts as 1, above 1024 as 1024. Sums wrap at 48 bits.

module integral_image_generator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [iig_pkg::WIDTH_BITS-1:0] cfg_wdata,
  iig_in_if.sink                         in_ch,
  iig_out_if.source                      out_ch
);

  logic                         rd_en;
  logic [iig_pkg::COL_BITS-1:0] rd_addr;
  logic [iig_pkg::SUM_BITS-1:0] rd_data;
  iig_pkg::s1_t                 s1;
  logic                         s1_valid;
  logic                         s1_adv;
  logic                         fwd;
  logic [iig_pkg::SUM_BITS-1:0] fwd_data;
  iig_pkg::wr_t                 wr;

  // accept stage
  iig_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .s1_adv   (s1_adv),
    .wr       (wr),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .s1       (s1),
    .s1_valid (s1_valid),
    .fwd      (fwd),
    .fwd_data (fwd_data)
  );

  // previous row line store
  iig_ram #(
    .WIDTH(iig_pkg::SUM_BITS),
    .DEPTH(iig_pkg::MAX_WIDTH)
  ) u_line (
    .clk  (clk),
    .we   (wr.en),
    .waddr(wr.addr),
    .wdata(wr.data),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // add and output stage
  iig_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1      (s1),
    .s1_valid(s1_valid),
    .fwd     (fwd),
    .fwd_data(fwd_data),
    .rd_data (rd_data),
    .s1_adv  (s1_adv),
    .wr      (wr),
    .out_ch  (out_ch)
  );

endmodule

### design/iig_checker.sv
// iig_checker: port-level assertions for the integral image generator
`timescale 1ns / 1ps

module iig_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [iig_pkg::AREA_BITS-1:0] area_sum,
  input logic                          row_end
);

  logic       in_acc, out_acc;
  logic [1:0] busy_r, busy_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // beats taken but not yet delivered
  always_comb begin
    busy_nxt = busy_r;
    if (in_acc && !out_acc) begin
      busy_nxt = busy_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      busy_nxt = busy_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= '0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(area_sum) && $stable(row_end))
    else $error("result changed while stalled");

  // at most two beats in flight
  a_busy_max: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r != 2'd3)
    else $error("more than two beats in flight");

  // empty block passes a beat through the accept stage and output register unstalled
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && busy_r == 2'd0 |-> ##2 out_valid)
    else $error("result late");

  // no back pressure without a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // nothing delivered without a beat taken
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == 2'd0 |-> !out_valid)
    else $error("result without a sample");

endmodule

bind integral_image_generator iig_checker u_iig_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_ch.valid),
  .in_ready (in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .area_sum (out_ch.area_sum),
  .row_end  (out_ch.row_end)
);

### verif/tb_top.sv
// tb_top: self-checking testbench for the integral image generator
`timescale 1ns / 1ps

module tb_top;

  localparam int HALF_PERIOD   = 6;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PRINT_CAP     = 100;
  localparam int FRAME_CAP     = 48;
  localparam int OPEN_ROW_LEN  = 60;

  localparam logic [iig_pkg::WIDTH_BITS-1:0]         WIDTH_RESET    = 11'd1024;
  localparam logic [iig_pkg::WIDTH_BITS-1:0]         WIDTH_ALL_ONES = '1;
  localparam logic signed [iig_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN     = 16'sh8000;
  localparam logic signed [iig_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX     = 16'sh7fff;

  // one expected result beat
  typedef struct packed {
    logic [iig_pkg::AREA_BITS-1:0] area_sum;
    logic                          row_end;
  } area_beat_t;

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [iig_pkg::WIDTH_BITS-1:0] cfg_wdata;

  iig_in_if  in_ch ();
  iig_out_if out_ch ();

  integral_image_generator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // summed-area predictor state
  logic [iig_pkg::WIDTH_BITS-1:0] width_reg;
  logic [iig_pkg::SUM_BITS-1:0]   row_acc;
  logic [iig_pkg::SUM_BITS-1:0]   line_sums [iig_pkg::MAX_WIDTH];
  bit                             line_written [iig_pkg::MAX_WIDTH];
  int unsigned                    col_pos;
  bit                             on_first_row;
  area_beat_t                     area_q [$];

  int          mismatch_count = 0;
  int          send_idle_pct  = 13;
  int          recv_stall_pct = 48;
  int unsigned cycle_count    = 0;

  always #HALF_PERIOD clk = ~clk;

  // row width in effect: 0 acts as 1, anything above the line store acts as its size
  function automatic int unsigned active_width();
    if (width_reg == 0) return 1;
    if (width_reg > iig_pkg::MAX_WIDTH) return iig_pkg::MAX_WIDTH;
    return width_reg;
  endfunction

  // advance the predictor by one accepted sample and queue its summed-area value
  function automatic void predict_area(logic signed [iig_pkg::SAMPLE_BITS-1:0] s, logic mark);
    int unsigned                  w;
    logic [iig_pkg::SUM_BITS-1:0] above;
    logic [iig_pkg::SUM_BITS-1:0] total;
    area_beat_t                   beat;
    w = active_width();
    if (mark) begin
      col_pos      = 0;
      row_acc      = '0;
      on_first_row = 1'b1;
      foreach (line_written[i]) line_written[i] = 1'b0;
    end
    if (col_pos >= iig_pkg::MAX_WIDTH) col_pos = 0;
    row_acc = row_acc + {{(iig_pkg::SUM_BITS-iig_pkg::SAMPLE_BITS){s[iig_pkg::SAMPLE_BITS-1]}}, s};
    above   = on_first_row ? '0 : line_sums[col_pos];
    total   = above + row_acc;
    line_sums[col_pos]    = total;
    line_written[col_pos] = 1'b1;
    beat.area_sum = iig_pkg::AREA_BITS'($signed(total));
    beat.row_end  = (col_pos + 1 >= w);
    area_q.push_back(beat);
    if (beat.row_end) begin
      col_pos      = 0;
      row_acc      = '0;
      on_first_row = 1'b0;
    end else begin
      col_pos++;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns: mismatch on %s, got %h, expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // send one sample beat, with random gaps before it
  task automatic put_sample(input logic signed [iig_pkg::SAMPLE_BITS-1:0] s, input logic fs);
    logic mark;
    mark = fs;
    // never let a row read a line store entry this frame has not written
    if (!mark && !on_first_row && !line_written[col_pos]) mark = 1'b1;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.sample      <= s;
    in_ch.frame_start <= mark;
    do @(posedge clk); while (!in_ch.ready);
    predict_area(s, mark);
    @(negedge clk);
  endtask

  // hold the sender until every expected beat has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (area_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_width(input logic [iig_pkg::WIDTH_BITS-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    width_reg = value;
  endtask

  // mostly narrow rows, sometimes the out-of-range and wide codes
  function automatic logic [iig_pkg::WIDTH_BITS-1:0] random_width();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 60) return iig_pkg::WIDTH_BITS'($urandom_range(8, 1));
    if (roll < 80) return iig_pkg::WIDTH_BITS'($urandom_range(40, 9));
    if (roll < 88) return '0;
    if (roll < 94) return WIDTH_ALL_ONES;
    return iig_pkg::WIDTH_BITS'($urandom_range(2047, 41));
  endfunction

  function automatic logic signed [iig_pkg::SAMPLE_BITS-1:0] random_sample();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8) return SAMPLE_MIN;
    if (roll < 16) return SAMPLE_MAX;
    return iig_pkg::SAMPLE_BITS'($urandom);
  endfunction

  // reset width, no frame mark, long first row at both sample extremes
  task automatic test_full_width_from_reset();
    for (int i = 0; i < OPEN_ROW_LEN; i++) put_sample(SAMPLE_MIN, 1'b0);
    for (int i = 0; i < OPEN_ROW_LEN; i++) put_sample(SAMPLE_MAX, 1'b0);
    put_sample(-16'sd1, 1'b0);
    put_sample(16'sd0, 1'b0);
    put_sample(16'sd1, 1'b0);
  endtask

  // width codes out of range, then a shrink below the current column
  task automatic test_width_limits();
    write_width('0);
    put_sample(SAMPLE_MAX, 1'b1);
    put_sample(SAMPLE_MAX, 1'b0);
    put_sample(SAMPLE_MIN, 1'b0);
    put_sample(-16'sd1, 1'b0);
    write_width(WIDTH_ALL_ONES);
    put_sample(SAMPLE_MIN, 1'b1);
    put_sample(16'sd100, 1'b0);
    put_sample(-16'sd3, 1'b0);
    put_sample(SAMPLE_MAX, 1'b0);
    // column already past the new width ends its row on the next beat
    write_width(11'd1);
    put_sample(16'sd5, 1'b0);
    put_sample(-16'sd7, 1'b0);
    put_sample(SAMPLE_MAX, 1'b0);
  endtask

  // shrink that leaves the current column inside the new width
  task automatic test_shrink_mid_row();
    write_width(11'd4);
    put_sample(16'sd1, 1'b1);
    put_sample(16'sd2, 1'b0);
    put_sample(16'sd3, 1'b0);
    put_sample(16'sd4, 1'b0);
    put_sample(-16'sd10, 1'b0);
    put_sample(16'sd20, 1'b0);
    write_width(11'd3);
    put_sample(16'sd30, 1'b0);
    put_sample(-16'sd40, 1'b0);
    put_sample(16'sd50, 1'b0);
  endtask

  // frame mark mid-row and on back-to-back beats
  task automatic test_frame_restart();
    write_width(11'd3);
    put_sample(16'sd11, 1'b1);
    put_sample(16'sd12, 1'b0);
    put_sample(16'sd13, 1'b1);
    put_sample(16'sd14, 1'b0);
    put_sample(16'sd15, 1'b0);
    put_sample(16'sd16, 1'b0);
    put_sample(16'sd17, 1'b1);
    put_sample(-16'sd18, 1'b1);
    put_sample(16'sd19, 1'b0);
  endtask

  // random frames: mostly well formed, some without a mark or restarted early
  task automatic test_random_frames(input int n_items, input int send_pct, input int recv_pct);
    int   sent;
    int   frame_len;
    int   change_at;
    int   roll;
    logic mark;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(2) == 0) write_width(random_width());
      frame_len = $urandom_range(3 * active_width() + 2, 1);
      if (frame_len > FRAME_CAP) frame_len = $urandom_range(FRAME_CAP, 8);
      change_at = ($urandom_range(9) == 0) ? int'($urandom_range(frame_len - 1)) : -1;
      for (int i = 0; i < frame_len; i++) begin
        if (i == change_at) write_width(random_width());
        roll = $urandom_range(99);
        mark = (i == 0) ? (roll >= 8) : (roll < 3);
        put_sample(random_sample(), mark);
        sent++;
      end
    end
  endtask

  // result receiver stalls at random
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    area_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (area_q.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_ch.area_sum), '0);
      end else begin
        want = area_q.pop_front();
        if (out_ch.area_sum !== want.area_sum)
          report_mismatch("area_sum", 64'(out_ch.area_sum), 64'(want.area_sum));
        if (out_ch.row_end !== want.row_end)
          report_mismatch("row_end", 64'(out_ch.row_end), 64'(want.row_end));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.sample      = '0;
    in_ch.frame_start = 1'b0;
    out_ch.ready      = 1'b0;
    width_reg         = WIDTH_RESET;
    row_acc           = '0;
    col_pos           = 0;
    on_first_row      = 1'b1;
    foreach (line_written[i]) line_written[i] = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct  = 13;
    recv_stall_pct = 48;
    test_full_width_from_reset();
    test_width_limits();
    test_shrink_mid_row();
    test_frame_restart();
    test_random_frames(80, 13, 48);
    test_random_frames(80, 48, 13);
    test_random_frames(80, 0, 0);
    settle();

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
